// File: hw/rtl/mla_pkg.sv
package mla_pkg;

  localparam int LAT_W     = 12;
  localparam int NUM_REGS  = 4;
  localparam int REG_IW    = 2;
  localparam int CFG_AW    = 4;
  localparam int LANE_W    = 2;
  localparam int IN_USER_W = 4;
  localparam int OB_DEPTH  = 4;
  localparam int OB_PW     = 2;
  localparam int OB_CW     = 3;

  typedef enum logic {
    ACT_DRY = 1'b0,
    ACT_AUX = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    SEL_PASS,
    SEL_ZERO,
    SEL_MEM
  } out_sel_t;

  typedef logic [LAT_W-1:0] lat_t;

endpackage

// File: hw/rtl/multi_lane_latency_aligner.sv
// Channel  Direction  Contents
// cfg_*    in/out     APB-style register port, four lane latency registers
// in_*     in         stream of dry and auxiliary stereo samples
// out_*    out        stream of aligned samples with the applied return delay
//
// One item is accepted every cycle while in_tready is high; its result is then queued.
// An item on a delaying line makes one write and one read of the delay store.
// Reset clears the write pointers and fill counts; the store itself needs no clearing pass.
// A four-entry output queue absorbs stalls; in_tready falls when the queue and the
// read stage together hold four transfers.
module multi_lane_latency_aligner #(
  parameter int NUM_LANES   = 4,
  parameter int MAX_DELAY   = 4095,
  parameter int SAMPLE_BITS = 24,
  localparam int IN_TD_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = 2 * SAMPLE_BITS + mla_pkg::LAT_W,
  localparam int OUT_TD_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mla_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: left_in, right_in.
  input  logic [IN_TD_W-1:0]             in_tdata,
  // Fields from bit 0: action, lane, block_start.
  input  logic [mla_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: left_out, right_out, return_delay.
  output logic [OUT_TD_W-1:0]            out_tdata
);

  localparam int NUM_LINES = NUM_LANES + 1;
  localparam int LINE_W    = $clog2(NUM_LINES);
  localparam int LINE_LEN  = MAX_DELAY + 1;
  localparam int OFF_W     = $clog2(LINE_LEN);
  localparam int CNT_W     = $clog2(LINE_LEN + 1);
  localparam int CMP_W     = (CNT_W > mla_pkg::LAT_W) ? CNT_W : mla_pkg::LAT_W;
  localparam int ADDR_W    = LINE_W + OFF_W;
  localparam int DEPTH     = NUM_LINES << OFF_W;
  localparam int WORD_W    = 2 * SAMPLE_BITS;
  localparam int LAT_CAP_I = (MAX_DELAY > 4095) ? 4095 : MAX_DELAY;
  localparam mla_pkg::lat_t LAT_CAP = mla_pkg::LAT_W'(LAT_CAP_I);
  localparam logic [LINE_W-1:0] DRY_LINE = LINE_W'(NUM_LANES);

  mla_pkg::lat_t cfg_lat_r [mla_pkg::NUM_REGS];
  mla_pkg::lat_t applied_lat_r [NUM_LANES];
  mla_pkg::lat_t applied_max_r;
  logic [OFF_W-1:0] wp_r [NUM_LINES];
  logic [CNT_W-1:0] fill_r [NUM_LINES];
  logic [WORD_W-1:0] delay_store_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic s1_v_r;
  mla_pkg::out_sel_t s1_sel_r;
  logic [WORD_W-1:0] s1_pass_r;
  mla_pkg::lat_t s1_ret_r;

  logic [OUT_W-1:0] ob_data_r [mla_pkg::OB_DEPTH];
  logic [mla_pkg::OB_PW-1:0] ob_wr_r, ob_rd_r;
  logic [mla_pkg::OB_CW-1:0] ob_cnt_r;

  logic cfg_we;
  logic [mla_pkg::REG_IW-1:0] cfg_idx;
  mla_pkg::lat_t cfg_val;

  logic in_acc, pop;
  logic is_dry, start, lane_ok, clear, do_apply, run, hit;
  logic [mla_pkg::LANE_W-1:0] in_lane;
  mla_pkg::lat_t tgt_lat [NUM_LANES];
  mla_pkg::lat_t tgt_max, eff_max, lane_lat, aux_d, d, ret;
  logic [LINE_W-1:0] line;
  logic [OFF_W-1:0] wp_sel, cur_wp, wp_step, rd_off;
  logic [CNT_W-1:0] fill_sel, cur_fill, new_fill;
  logic [CMP_W-1:0] wp_ext, d_ext;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] in_word, s1_word;
  logic [OFF_W-1:0] wp_nxt [NUM_LINES];
  logic [CNT_W-1:0] fill_nxt [NUM_LINES];
  mla_pkg::out_sel_t sel;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[mla_pkg::CFG_AW-1:2];
  assign cfg_val    = (cfg_pwdata[mla_pkg::LAT_W-1:0] > LAT_CAP) ? LAT_CAP
                                                               : cfg_pwdata[mla_pkg::LAT_W-1:0];
  assign cfg_prdata = 32'(cfg_lat_r[cfg_idx]);

  assign in_acc  = in_tvalid && in_tready;
  assign is_dry  = (mla_pkg::action_t'(in_tuser[0]) == mla_pkg::ACT_DRY);
  assign in_lane = in_tuser[2:1];
  assign start   = in_tuser[3];
  assign in_word = in_tdata[WORD_W-1:0];

  always_comb begin
    tgt_max = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      tgt_lat[k] = (k < mla_pkg::NUM_REGS) ? cfg_lat_r[mla_pkg::REG_IW'(k)] : '0;
      if (tgt_lat[k] > tgt_max) begin
        tgt_max = tgt_lat[k];
      end
    end
  end

  always_comb begin
    lane_lat = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (int'(in_lane) == k) begin
        lane_lat = applied_lat_r[k];
      end
    end
    lane_ok  = int'(in_lane) < NUM_LANES;
    do_apply = is_dry && start;
    eff_max  = do_apply ? tgt_max : applied_max_r;
    clear    = do_apply && (applied_max_r == '0) && (tgt_max != '0);
    aux_d    = (applied_max_r > lane_lat) ? applied_max_r - lane_lat : '0;
    d        = is_dry ? eff_max : aux_d;
    ret      = is_dry ? eff_max : (lane_ok ? aux_d : '0);
    run      = (is_dry || lane_ok) && (d != '0);
    line     = is_dry ? DRY_LINE : LINE_W'(in_lane);

    wp_sel   = '0;
    fill_sel = '0;
    for (int j = 0; j < NUM_LINES; j++) begin
      if (int'(line) == j) begin
        wp_sel   = wp_r[j];
        fill_sel = fill_r[j];
      end
    end
    cur_wp   = clear ? '0 : wp_sel;
    cur_fill = clear ? '0 : fill_sel;
    new_fill = (int'(cur_fill) < LINE_LEN) ? cur_fill + 1'b1 : cur_fill;
    d_ext    = CMP_W'(d);
    wp_ext   = CMP_W'(cur_wp);
    hit      = CMP_W'(new_fill) > d_ext;
    rd_off   = (wp_ext >= d_ext) ? OFF_W'(wp_ext - d_ext)
                                 : OFF_W'(wp_ext + CMP_W'(LINE_LEN) - d_ext);
    wp_step  = (int'(cur_wp) == LINE_LEN - 1) ? '0 : cur_wp + 1'b1;
    waddr    = {line, cur_wp};
    raddr    = {line, rd_off};

    for (int j = 0; j < NUM_LINES; j++) begin
      wp_nxt[j]   = clear ? '0 : wp_r[j];
      fill_nxt[j] = clear ? '0 : fill_r[j];
      if (run && (int'(line) == j)) begin
        wp_nxt[j]   = wp_step;
        fill_nxt[j] = new_fill;
      end
    end

    if (!run) begin
      sel = mla_pkg::SEL_PASS;
    end else if (hit) begin
      sel = mla_pkg::SEL_MEM;
    end else begin
      sel = mla_pkg::SEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && run) begin
      delay_store_r[waddr] <= in_word;
      rdata_r <= delay_store_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mla_pkg::NUM_REGS; i++) begin
        cfg_lat_r[i] <= '0;
      end
      for (int k = 0; k < NUM_LANES; k++) begin
        applied_lat_r[k] <= '0;
      end
      applied_max_r <= '0;
      for (int j = 0; j < NUM_LINES; j++) begin
        wp_r[j]   <= '0;
        fill_r[j] <= '0;
      end
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_lat_r[cfg_idx] <= cfg_val;
      end
      s1_v_r <= in_acc;
      if (in_acc) begin
        if (do_apply) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            applied_lat_r[k] <= tgt_lat[k];
          end
          applied_max_r <= tgt_max;
        end
        for (int j = 0; j < NUM_LINES; j++) begin
          wp_r[j]   <= wp_nxt[j];
          fill_r[j] <= fill_nxt[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sel_r  <= sel;
      s1_pass_r <= in_word;
      s1_ret_r  <= ret;
    end
  end

  always_comb begin
    unique case (s1_sel_r)
      mla_pkg::SEL_PASS: s1_word = s1_pass_r;
      mla_pkg::SEL_MEM:  s1_word = rdata_r;
      mla_pkg::SEL_ZERO: s1_word = '0;
      default:           s1_word = '0;
    endcase
  end

  assign out_tvalid = (ob_cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = OUT_TD_W'(ob_data_r[ob_rd_r]);
  assign in_tready  = (ob_cnt_r + mla_pkg::OB_CW'(s1_v_r)) < mla_pkg::OB_CW'(mla_pkg::OB_DEPTH);

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      ob_data_r[ob_wr_r] <= {s1_ret_r, s1_word};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (s1_v_r) begin
        ob_wr_r <= ob_wr_r + 1'b1;
      end
      if (pop) begin
        ob_rd_r <= ob_rd_r + 1'b1;
      end
      ob_cnt_r <= ob_cnt_r + mla_pkg::OB_CW'(s1_v_r) - mla_pkg::OB_CW'(pop);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= mla_pkg::OB_CW'(mla_pkg::OB_DEPTH))
    else $error("output queue overflow");

  a_port_apart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && run |-> raddr != waddr)
    else $error("store read and write address collide");

  a_apply_max: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && do_apply |=> applied_max_r == $past(tgt_max))
    else $error("applied maximum not taken at block start");

endmodule
